[design/rllt_pkg.sv]
// Shared types and codes for the run-length line table.
`timescale 1ns / 1ps

package rllt_pkg;

    localparam int LINE_W = 24;
    localparam int OFFS_W = 24;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_EXTENDED = 3'd1,
        ST_HIT      = 3'd2,
        ST_FULL     = 3'd3,
        ST_MISS     = 3'd4
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [LINE_W-1:0]  line;
        logic [OFFS_W-1:0]  offset;
    } req_t;

    typedef struct packed {
        logic [LINE_W-1:0]  found_line;
        status_t            status;
    } resp_t;

endpackage

[design/rllt_table.sv]
// Run storage, append logic and lower-bound search sequencer.
`timescale 1ns / 1ps

module rllt_table
    import rllt_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    output logic  resp_valid,
    input  logic  resp_ready,
    output resp_t resp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESP
    } state_t;

    // run storage, one shared read address, registered read data
    logic [LINE_W-1:0] run_line       [TABLE_DEPTH];
    logic [OFFS_W-1:0] run_end_offset [TABLE_DEPTH];
    logic [LINE_W-1:0] line_q;
    logic [OFFS_W-1:0] end_q;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [AW-1:0]     mid_reg, mid_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    status_t           status_reg, status_next;
    req_t              req_reg, req_next;
    logic [LINE_W-1:0] last_line_reg, last_line_next;

    logic              line_we;
    logic              offs_we;
    logic [AW-1:0]     wr_addr;

    // shared compare / halving step
    logic              probe_lt;
    logic [CW-1:0]     lo_s;
    logic [CW-1:0]     hi_s;
    logic [AW-1:0]     mid_s;

    assign probe_lt = end_q < req_reg.offset;
    assign lo_s     = probe_lt ? (CW'(mid_reg) + 1'b1) : lo_reg;
    assign hi_s     = probe_lt ? hi_reg : CW'(mid_reg);
    assign mid_s    = AW'(lo_s + ((hi_s - lo_s) >> 1));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        rd_addr_next   = rd_addr_reg;
        status_next    = status_reg;
        req_next       = req_reg;
        last_line_next = last_line_reg;
        line_we        = 1'b0;
        offs_we        = 1'b0;
        wr_addr        = '0;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next = req;
                    if (req.op == OP_APPEND) begin
                        if (count_reg != '0 && last_line_reg == req.line) begin
                            offs_we     = 1'b1;
                            wr_addr     = AW'(count_reg - 1'b1);
                            status_next = ST_EXTENDED;
                        end else if (count_reg == CW'(TABLE_DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            line_we        = 1'b1;
                            offs_we        = 1'b1;
                            wr_addr        = AW'(count_reg);
                            count_next     = count_reg + 1'b1;
                            last_line_next = req.line;
                            status_next    = ST_ADDED;
                        end
                        state_next = S_RESP;
                    end else if (count_reg == '0) begin
                        status_next = ST_MISS;
                        state_next  = S_RESP;
                    end else begin
                        lo_next      = '0;
                        hi_next      = count_reg;
                        mid_next     = AW'(count_reg >> 1);
                        rd_addr_next = AW'(count_reg >> 1);
                        state_next   = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                lo_next = lo_s;
                hi_next = hi_s;
                if (lo_s < hi_s) begin
                    mid_next     = mid_s;
                    rd_addr_next = mid_s;
                end else begin
                    // fetch the line of the lower bound; a miss ignores it
                    rd_addr_next = AW'(lo_s);
                    status_next  = (lo_s < count_reg) ? ST_HIT : ST_MISS;
                    state_next   = S_RESP;
                end
            end
            S_RESP: begin
                if (resp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        rd_addr_reg   <= rd_addr_next;
        status_reg    <= status_next;
        req_reg       <= req_next;
        last_line_reg <= last_line_next;
    end

    always_ff @(posedge aclk) begin
        if (line_we) begin
            run_line[wr_addr] <= req.line;
        end
        if (offs_we) begin
            run_end_offset[wr_addr] <= req.offset;
        end
        line_q <= run_line[rd_addr_next];
        end_q  <= run_end_offset[rd_addr_next];
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign resp_valid      = (state_reg == S_RESP);
    assign resp.status     = status_reg;
    assign resp.found_line = (status_reg == ST_HIT) ? line_q : '0;

endmodule

[design/run_length_line_table.sv]
// Top level of the run-length line table.
`timescale 1ns / 1ps
//
// Keeps up to TABLE_DEPTH runs of (line, last code offset). The s_ channel
// takes one item: s_tuser selects append (0) or lookup (1), s_tdata carries
// line number and code offset. Each item yields exactly one m_ item: the
// found line in m_tdata and the status code in m_tuser.
// Append: the result passes the response step and the output register;
// the last line is kept in a register, so no table read is needed.
// Lookup: one end-offset read and compare per cycle in a shared unit, at
// most ceil(log2(count+1)) probes, then the line read at the lower bound
// and the hand-over to the output register.
// A new item is taken once the previous result has left the sequencer;
// that result may still wait in the output register meanwhile.
// Reset empties the table (run count to zero, no memory clearing) and
// drops any pending result. While m_tready is low the result holds and the
// sequencer waits at its response step after one further item.
module run_length_line_table
    import rllt_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // line_number[23:0], code_offset[47:24]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // found_line[23:0]
    output logic [2:0]  m_tuser    // status[2:0]
);

    req_t  req;
    resp_t resp;
    logic  resp_valid;
    logic  resp_ready;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [LINE_W-1:0] m_tdata_reg, m_tdata_next;
    status_t           m_tuser_reg, m_tuser_next;

    assign req.op     = op_t'(s_tuser[0]);
    assign req.line   = s_tdata[LINE_W-1:0];
    assign req.offset = s_tdata[LINE_W+OFFS_W-1:LINE_W];

    rllt_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    assign resp_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (resp_valid && resp_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = resp.found_line;
            m_tuser_next  = resp.status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[design/rllt_checker.sv]
// Port-level assertions for the run-length line table, with bind.
`timescale 1ns / 1ps

module rllt_checker
    import rllt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // only a lookup hit carries a line
    a_line_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_HIT) |-> m_tdata == '0)
        else $error("found_line nonzero on a non-hit result");

    // the sequencer is not ready again in the cycle after it takes an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while sequencer still busy");

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind run_length_line_table rllt_checker u_rllt_checker (.*);

[test/tb.sv]
// Self-checking testbench for the run-length line table.
`timescale 1ns / 1ps

module tb;
    import rllt_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int LIMIT     = 400000;
    localparam int TAIL_WAIT = 16;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    run_length_line_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predicted table contents
    logic [LINE_W-1:0] tab_line [DEPTH];
    logic [OFFS_W-1:0] tab_end  [DEPTH];
    int                tab_count = 0;

    req_t  req_q[$];
    resp_t resp_due_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;

    // generator shadow: only what is needed to shape sequences
    int                gen_runs      = 0;
    logic [LINE_W-1:0] gen_last_line = '0;
    logic [OFFS_W-1:0] gen_off       = '0;

    function automatic resp_t table_step(op_t op, logic [LINE_W-1:0] line,
                                         logic [OFFS_W-1:0] offs);
        resp_t r;
        int    lo;
        int    hi;
        int    mid;
        r.found_line = '0;
        if (op == OP_APPEND) begin
            if (tab_count > 0 && tab_line[tab_count-1] == line) begin
                tab_end[tab_count-1] = offs;
                r.status = ST_EXTENDED;
            end else if (tab_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                tab_line[tab_count] = line;
                tab_end[tab_count]  = offs;
                tab_count++;
                r.status = ST_ADDED;
            end
        end else begin
            // lower bound: first run whose end offset is >= offs
            lo = 0;
            hi = tab_count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (tab_end[mid] < offs)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo >= tab_count) begin
                r.status = ST_MISS;
            end else begin
                r.found_line = tab_line[lo];
                r.status     = ST_HIT;
            end
        end
        return r;
    endfunction

    task automatic queue_append(logic [LINE_W-1:0] line, logic [OFFS_W-1:0] offs);
        req_t r;
        r.op     = OP_APPEND;
        r.line   = line;
        r.offset = offs;
        req_q.push_back(r);
        if (!(gen_runs > 0 && line == gen_last_line) && gen_runs < DEPTH) begin
            gen_runs++;
            gen_last_line = line;
        end
    endtask

    task automatic queue_lookup(logic [LINE_W-1:0] line, logic [OFFS_W-1:0] offs);
        req_t r;
        r.op     = OP_LOOKUP;
        r.line   = line;
        r.offset = offs;
        req_q.push_back(r);
    endtask

    // one random item; new_pct sets the percentage of items that are appends of a new line
    task automatic queue_mixed(int new_pct);
        int                pick;
        int                sel;
        logic [LINE_W-1:0] l;
        pick = $urandom_range(99);
        if (pick < new_pct) begin
            l = LINE_W'($urandom);
            while (l == gen_last_line)
                l = LINE_W'($urandom);
            gen_off = gen_off + OFFS_W'($urandom_range(0, 16));
            queue_append(l, gen_off);
        end else if (pick < new_pct + 10) begin
            gen_off = gen_off + OFFS_W'($urandom_range(0, 4));
            queue_append(gen_last_line, gen_off);
        end else if (pick < new_pct + 13) begin
            // noise: random line and offset, breaks offset order
            queue_append(LINE_W'($urandom), OFFS_W'($urandom));
        end else begin
            sel = $urandom_range(9);
            if (sel < 8)
                queue_lookup(LINE_W'($urandom), OFFS_W'($urandom_range(0, gen_off + 8)));
            else
                queue_lookup(LINE_W'($urandom), OFFS_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (req_q.size() > 0 || s_tvalid || resp_due_q.size() > 0)
            @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                resp_due_q.push_back(table_step(op_t'(s_tuser[0]), s_tdata[23:0],
                                                s_tdata[47:24]));
            if (!s_tvalid || s_tready) begin
                if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {r.offset, r.line};
                    s_tuser  <= r.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        resp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (resp_due_q.size() == 0) begin
                    $display("%0t: unexpected result line=%h status=%0d",
                             $time, m_tdata, m_tuser);
                    err_cnt++;
                end else begin
                    e = resp_due_q.pop_front();
                    if (m_tdata !== e.found_line) begin
                        $display("%0t: found_line expected %h actual %h",
                                 $time, e.found_line, m_tdata);
                        err_cnt++;
                    end
                    if (m_tuser !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, m_tuser);
                        err_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 1: sender rarely idle, receiver mostly stalled
        send_idle_pct = 10;
        recv_idle_pct = 81;
        queue_lookup(24'h000000, 24'h000000);        // empty table
        queue_lookup(24'hFFFFFF, 24'hFFFFFF);
        queue_append(24'h000000, 24'h000000);
        queue_append(24'h000000, 24'h000005);        // same line extends
        queue_append(24'hFFFFFF, 24'h00000A);
        queue_append(24'h000001, 24'h000014);
        queue_append(24'h000001, 24'hFFFFFF);        // end offset at max
        queue_lookup(24'h123456, 24'hFFFFFF);        // hits last run
        queue_append(24'h000001, 24'h00001E);        // pulled back down
        queue_lookup(24'h000000, 24'h000000);
        queue_lookup(24'h000000, 24'h000005);
        queue_lookup(24'h000000, 24'h000006);
        queue_lookup(24'h000000, 24'h00000A);
        queue_lookup(24'h000000, 24'h00001E);
        queue_lookup(24'h000000, 24'h00001F);        // past the last run
        queue_lookup(24'h000000, 24'hFFFFFF);
        queue_append(24'hAAAAAA, 24'h000028);
        queue_append(24'h555555, 24'h000032);
        queue_lookup(24'hFFFFFF, 24'h00002D);
        gen_off = 24'h000032;
        repeat (150) queue_mixed(60);
        wait_drained();

        // phase 2: sender mostly idle, receiver rarely stalled
        send_idle_pct = 81;
        recv_idle_pct = 10;
        repeat (150) queue_mixed(60);
        wait_drained();

        // phase 3: no idling; fill the table, then work against a full table
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (gen_runs < DEPTH)
            queue_mixed(85);
        repeat (60) queue_mixed(40);
        queue_lookup(24'h000000, 24'hFFFFFF);
        wait_drained();

        repeat (TAIL_WAIT) @(posedge aclk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
